[rtl/tpd_pkg.sv]
// Package: shared types, constants and helpers for the tree path distance block.
`default_nettype none
package tpd_pkg;

  localparam int unsigned NODES   = 65536;
  localparam int unsigned LEVELS  = 16;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TADDR_W = NODE_W + LVL_W;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ACC_W   = DEPTH_W + 4;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

  localparam logic [OP_W-1:0] OP_ROOT  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] PAIR_AC = 2'd0;
  localparam logic [1:0] PAIR_BC = 2'd1;
  localparam logic [1:0] PAIR_AB = 2'd2;

  typedef struct packed {
    logic              absent;
    logic [NODE_W-1:0] idx;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ROOT_WR,
    CMD_CH_RDP,
    CMD_CH_WDEP,
    CMD_CH_WR,
    CMD_CH_RD,
    CMD_CH_GET,
    CMD_RDX,
    CMD_RDY,
    CMD_ORD,
    CMD_LIFT_RD,
    CMD_LIFT_GET,
    CMD_EQ,
    CMD_RU,
    CMD_RV,
    CMD_CMP,
    CMD_R0,
    CMD_R0G,
    CMD_RDL,
    CMD_ACC,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e             op;
    logic [LVL_W-1:0] lvl;
    logic [1:0]       pair;
  } cmd_t;

  typedef struct packed {
    logic cur_absent;
    logic lift_bit;
    logic u_eq_v;
    logic out_busy;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROOT,
    ST_CH_RDP,
    ST_CH_WDEP,
    ST_CH_WR,
    ST_CH_RD,
    ST_CH_GET,
    ST_Q_RDX,
    ST_Q_RDY,
    ST_Q_ORD,
    ST_Q_LIFT,
    ST_Q_LIFTG,
    ST_Q_EQ,
    ST_Q_RU,
    ST_Q_RV,
    ST_Q_CMP,
    ST_Q_R0,
    ST_Q_R0G,
    ST_Q_RDL,
    ST_Q_ACC,
    ST_Q_FIN
  } state_e;

  function automatic logic [TADDR_W-1:0] tbl_addr(input logic [NODE_W-1:0] node,
                                                  input logic [LVL_W-1:0] lvl);
    return {node, lvl};
  endfunction

endpackage
`default_nettype wire

[rtl/tpd_if.sv]
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface tpd_in_if;
  logic                       valid;
  logic                       ready;
  logic [tpd_pkg::OP_W-1:0]   opcode;
  logic [tpd_pkg::NODE_W-1:0] node_a;
  logic [tpd_pkg::NODE_W-1:0] node_b;
  logic [tpd_pkg::NODE_W-1:0] node_c;
  modport source (output valid, opcode, node_a, node_b, node_c, input ready);
  modport sink (input valid, opcode, node_a, node_b, node_c, output ready);
endinterface

interface tpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [tpd_pkg::DIST_W-1:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface
`default_nettype wire

[rtl/tpd_ctrl.sv]
// Controller: sequences inserts and the three LCA searches of a query.
`default_nettype none
module tpd_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [tpd_pkg::OP_W-1:0] in_opcode_i,
  output logic                          in_ready_o,
  input  wire tpd_pkg::sts_t            sts_i,
  output tpd_pkg::cmd_t                 cmd_o
);

  tpd_pkg::state_e             state_q, state_d;
  logic [tpd_pkg::LVL_W-1:0]   lvl_q, lvl_d;
  logic [1:0]                  pair_q, pair_d;

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    pair_d  = pair_q;
    unique case (state_q)
      tpd_pkg::ST_IDLE: begin
        lvl_d  = '0;
        pair_d = tpd_pkg::PAIR_AC;
        if (in_valid_i) begin
          unique case (in_opcode_i)
            tpd_pkg::OP_ROOT:  state_d = tpd_pkg::ST_ROOT;
            tpd_pkg::OP_CHILD: state_d = tpd_pkg::ST_CH_RDP;
            tpd_pkg::OP_QUERY: state_d = tpd_pkg::ST_Q_RDX;
            default:           state_d = tpd_pkg::ST_IDLE;
          endcase
        end
      end
      tpd_pkg::ST_ROOT: begin
        if (lvl_q == tpd_pkg::LVL_MAX) state_d = tpd_pkg::ST_IDLE;
        else lvl_d = lvl_q + 1'b1;
      end
      tpd_pkg::ST_CH_RDP:  state_d = tpd_pkg::ST_CH_WDEP;
      tpd_pkg::ST_CH_WDEP: state_d = tpd_pkg::ST_CH_WR;
      tpd_pkg::ST_CH_WR: begin
        if (lvl_q == tpd_pkg::LVL_MAX) state_d = tpd_pkg::ST_IDLE;
        else if (sts_i.cur_absent) lvl_d = lvl_q + 1'b1;
        else state_d = tpd_pkg::ST_CH_RD;
      end
      tpd_pkg::ST_CH_RD: state_d = tpd_pkg::ST_CH_GET;
      tpd_pkg::ST_CH_GET: begin
        lvl_d   = lvl_q + 1'b1;
        state_d = tpd_pkg::ST_CH_WR;
      end
      tpd_pkg::ST_Q_RDX: state_d = tpd_pkg::ST_Q_RDY;
      tpd_pkg::ST_Q_RDY: state_d = tpd_pkg::ST_Q_ORD;
      tpd_pkg::ST_Q_ORD: begin
        lvl_d   = '0;
        state_d = tpd_pkg::ST_Q_LIFT;
      end
      tpd_pkg::ST_Q_LIFT: begin
        if (sts_i.lift_bit) state_d = tpd_pkg::ST_Q_LIFTG;
        else if (lvl_q == tpd_pkg::LVL_MAX) state_d = tpd_pkg::ST_Q_EQ;
        else lvl_d = lvl_q + 1'b1;
      end
      tpd_pkg::ST_Q_LIFTG: begin
        if (lvl_q == tpd_pkg::LVL_MAX) state_d = tpd_pkg::ST_Q_EQ;
        else begin
          lvl_d   = lvl_q + 1'b1;
          state_d = tpd_pkg::ST_Q_LIFT;
        end
      end
      tpd_pkg::ST_Q_EQ: begin
        lvl_d   = tpd_pkg::LVL_MAX;
        state_d = sts_i.u_eq_v ? tpd_pkg::ST_Q_RDL : tpd_pkg::ST_Q_RU;
      end
      tpd_pkg::ST_Q_RU: state_d = tpd_pkg::ST_Q_RV;
      tpd_pkg::ST_Q_RV: state_d = tpd_pkg::ST_Q_CMP;
      tpd_pkg::ST_Q_CMP: begin
        if (lvl_q == '0) state_d = tpd_pkg::ST_Q_R0;
        else begin
          lvl_d   = lvl_q - 1'b1;
          state_d = tpd_pkg::ST_Q_RU;
        end
      end
      tpd_pkg::ST_Q_R0:  state_d = tpd_pkg::ST_Q_R0G;
      tpd_pkg::ST_Q_R0G: state_d = tpd_pkg::ST_Q_RDL;
      tpd_pkg::ST_Q_RDL: state_d = tpd_pkg::ST_Q_ACC;
      tpd_pkg::ST_Q_ACC: begin
        if (pair_q == tpd_pkg::PAIR_AB) state_d = tpd_pkg::ST_Q_FIN;
        else begin
          pair_d  = pair_q + 1'b1;
          state_d = tpd_pkg::ST_Q_RDX;
        end
      end
      tpd_pkg::ST_Q_FIN: begin
        if (!sts_i.out_busy) state_d = tpd_pkg::ST_IDLE;
      end
      default: state_d = tpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == tpd_pkg::ST_IDLE);
    cmd_o.lvl   = lvl_q;
    cmd_o.pair  = pair_q;
    unique case (state_q)
      tpd_pkg::ST_IDLE:    cmd_o.op = in_valid_i ? tpd_pkg::CMD_LOAD : tpd_pkg::CMD_NONE;
      tpd_pkg::ST_ROOT:    cmd_o.op = tpd_pkg::CMD_ROOT_WR;
      tpd_pkg::ST_CH_RDP:  cmd_o.op = tpd_pkg::CMD_CH_RDP;
      tpd_pkg::ST_CH_WDEP: cmd_o.op = tpd_pkg::CMD_CH_WDEP;
      tpd_pkg::ST_CH_WR:   cmd_o.op = tpd_pkg::CMD_CH_WR;
      tpd_pkg::ST_CH_RD:   cmd_o.op = tpd_pkg::CMD_CH_RD;
      tpd_pkg::ST_CH_GET:  cmd_o.op = tpd_pkg::CMD_CH_GET;
      tpd_pkg::ST_Q_RDX:   cmd_o.op = tpd_pkg::CMD_RDX;
      tpd_pkg::ST_Q_RDY:   cmd_o.op = tpd_pkg::CMD_RDY;
      tpd_pkg::ST_Q_ORD:   cmd_o.op = tpd_pkg::CMD_ORD;
      tpd_pkg::ST_Q_LIFT:  cmd_o.op = tpd_pkg::CMD_LIFT_RD;
      tpd_pkg::ST_Q_LIFTG: cmd_o.op = tpd_pkg::CMD_LIFT_GET;
      tpd_pkg::ST_Q_EQ:    cmd_o.op = tpd_pkg::CMD_EQ;
      tpd_pkg::ST_Q_RU:    cmd_o.op = tpd_pkg::CMD_RU;
      tpd_pkg::ST_Q_RV:    cmd_o.op = tpd_pkg::CMD_RV;
      tpd_pkg::ST_Q_CMP:   cmd_o.op = tpd_pkg::CMD_CMP;
      tpd_pkg::ST_Q_R0:    cmd_o.op = tpd_pkg::CMD_R0;
      tpd_pkg::ST_Q_R0G:   cmd_o.op = tpd_pkg::CMD_R0G;
      tpd_pkg::ST_Q_RDL:   cmd_o.op = tpd_pkg::CMD_RDL;
      tpd_pkg::ST_Q_ACC:   cmd_o.op = tpd_pkg::CMD_ACC;
      tpd_pkg::ST_Q_FIN:   cmd_o.op = sts_i.out_busy ? tpd_pkg::CMD_NONE : tpd_pkg::CMD_FIN;
      default:             cmd_o.op = tpd_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpd_pkg::ST_IDLE;
      lvl_q   <= '0;
      pair_q  <= tpd_pkg::PAIR_AC;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      pair_q  <= pair_d;
    end
  end

endmodule
`default_nettype wire

[rtl/tpd_dpath.sv]
// Datapath: ancestor and depth memories, walkers, distance accumulator, result register.
`default_nettype none
module tpd_dpath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tpd_pkg::cmd_t              cmd_i,
  output tpd_pkg::sts_t                   sts_o,
  input  wire logic [tpd_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [tpd_pkg::NODE_W-1:0] node_b_i,
  input  wire logic [tpd_pkg::NODE_W-1:0] node_c_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tpd_pkg::DIST_W-1:0]      distance_o
);

  localparam int unsigned NW = tpd_pkg::NODE_W;
  localparam int unsigned DW = tpd_pkg::DEPTH_W;
  localparam int unsigned AW = tpd_pkg::ACC_W;

  tpd_pkg::entry_t tbl_mem [2**tpd_pkg::TADDR_W];
  logic [DW-1:0]   dep_mem [2**NW];

  logic                        tbl_we, tbl_re, dep_we, dep_re;
  logic [tpd_pkg::TADDR_W-1:0] tbl_waddr, tbl_raddr;
  tpd_pkg::entry_t             tbl_wdata, tbl_rd_q;
  logic [NW-1:0]               dep_waddr, dep_raddr;
  logic [DW-1:0]               dep_wdata, dep_rd_q;

  logic [NW-1:0]          a_q, b_q, c_q, u_q, v_q, lca_q, x_s, y_s;
  logic [DW-1:0]          dx_q, dy_q, diff_q;
  tpd_pkg::entry_t        eu_q, cur_q;
  logic signed [AW-1:0]   acc_q, pl_s;
  logic [tpd_pkg::DIST_W-1:0] dist_q, res_s;
  logic                   ovld_q;

  always_comb begin
    unique case (cmd_i.pair)
      tpd_pkg::PAIR_AC: begin x_s = a_q; y_s = c_q; end
      tpd_pkg::PAIR_BC: begin x_s = b_q; y_s = c_q; end
      default:          begin x_s = a_q; y_s = b_q; end
    endcase
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    dep_we    = 1'b0;
    dep_re    = 1'b0;
    tbl_waddr = tpd_pkg::tbl_addr(a_q, cmd_i.lvl);
    tbl_wdata = cur_q;
    tbl_raddr = tpd_pkg::tbl_addr(u_q, cmd_i.lvl);
    dep_waddr = a_q;
    dep_wdata = (dep_rd_q == '1) ? dep_rd_q : dep_rd_q + 1'b1;
    dep_raddr = x_s;
    unique case (cmd_i.op)
      tpd_pkg::CMD_ROOT_WR: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{absent: 1'b1, idx: '0};
        dep_we    = (cmd_i.lvl == '0);
        dep_wdata = '0;
      end
      tpd_pkg::CMD_CH_RDP: begin dep_re = 1'b1; dep_raddr = b_q; end
      tpd_pkg::CMD_CH_WDEP: dep_we = 1'b1;
      tpd_pkg::CMD_CH_WR: tbl_we = 1'b1;
      tpd_pkg::CMD_CH_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = tpd_pkg::tbl_addr(cur_q.idx, cmd_i.lvl);
      end
      tpd_pkg::CMD_RDX: dep_re = 1'b1;
      tpd_pkg::CMD_RDY: begin dep_re = 1'b1; dep_raddr = y_s; end
      tpd_pkg::CMD_LIFT_RD, tpd_pkg::CMD_RV: begin
        tbl_re    = 1'b1;
        tbl_raddr = tpd_pkg::tbl_addr(v_q, cmd_i.lvl);
      end
      tpd_pkg::CMD_RU: tbl_re = 1'b1;
      tpd_pkg::CMD_R0: begin
        tbl_re    = 1'b1;
        tbl_raddr = tpd_pkg::tbl_addr(u_q, '0);
      end
      tpd_pkg::CMD_RDL: begin dep_re = 1'b1; dep_raddr = lca_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    if (dep_re) dep_rd_q <= dep_mem[dep_raddr];
  end

  assign pl_s = signed'(AW'(dx_q)) + signed'(AW'(dy_q)) - signed'(AW'({dep_rd_q, 1'b0}));

  always_comb begin
    if (acc_q[AW-1]) res_s = '0;
    else if (|acc_q[AW-2:tpd_pkg::DIST_W+1]) res_s = '1;
    else res_s = acc_q[tpd_pkg::DIST_W:1];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      tpd_pkg::CMD_LOAD: begin
        a_q   <= node_a_i;
        b_q   <= node_b_i;
        c_q   <= node_c_i;
        acc_q <= '0;
      end
      tpd_pkg::CMD_CH_WDEP: cur_q <= '{absent: 1'b0, idx: b_q};
      tpd_pkg::CMD_CH_GET:  cur_q <= tbl_rd_q;
      tpd_pkg::CMD_RDY:     dx_q <= dep_rd_q;
      tpd_pkg::CMD_ORD: begin
        dy_q <= dep_rd_q;
        if (dx_q > dep_rd_q) begin
          u_q    <= y_s;
          v_q    <= x_s;
          diff_q <= dx_q - dep_rd_q;
        end else begin
          u_q    <= x_s;
          v_q    <= y_s;
          diff_q <= dep_rd_q - dx_q;
        end
      end
      tpd_pkg::CMD_LIFT_GET: if (!tbl_rd_q.absent) v_q <= tbl_rd_q.idx;
      tpd_pkg::CMD_EQ:       lca_q <= u_q;
      tpd_pkg::CMD_RV:       eu_q <= tbl_rd_q;
      tpd_pkg::CMD_CMP: begin
        if (eu_q != tbl_rd_q) begin
          if (!eu_q.absent) u_q <= eu_q.idx;
          if (!tbl_rd_q.absent) v_q <= tbl_rd_q.idx;
        end
      end
      tpd_pkg::CMD_R0G: lca_q <= tbl_rd_q.absent ? u_q : tbl_rd_q.idx;
      tpd_pkg::CMD_ACC: acc_q <= (cmd_i.pair == tpd_pkg::PAIR_AB) ? acc_q - pl_s : acc_q + pl_s;
      tpd_pkg::CMD_FIN: dist_q <= res_s;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i.op == tpd_pkg::CMD_FIN) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  assign sts_o.cur_absent = cur_q.absent;
  assign sts_o.lift_bit   = diff_q[cmd_i.lvl];
  assign sts_o.u_eq_v     = (u_q == v_q);
  assign sts_o.out_busy   = ovld_q && !out_ready_i;

  assign out_valid_o = ovld_q;
  assign distance_o  = dist_q;

endmodule
`default_nettype wire

[rtl/tree_path_distance_query.sv]
// Top level: tree path distance query block (binary-lifting LCA).
//
// in_i carries words {opcode, node_a, node_b, node_c}; out_o carries
// one distance word per query and nothing for inserts or opcode 3.
// One word is handled at a time; in_i.ready is high only while idle.
// Root insert: one ancestor-row write per level.
// Child insert: a write per level and a dependent read per present ancestor.
// Query: three LCA searches, each a lift pass of 16 levels with a table
// read at every level, taken when that depth-difference bit is set, and a
// descent of 16 levels with two reads per level when the lift misses,
// all on the single read port of the ancestor memory.
// The result sits in an output register; the next word is taken while it
// waits. A query finishing while the register is still full waits for it.
// Reset clears the controller and the output valid; memories are not
// cleared and hold nothing meaningful until written.
`default_nettype none
module tree_path_distance_query (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpd_in_if.sink     in_i,
  tpd_out_if.source  out_o
);

  tpd_pkg::cmd_t cmd;
  tpd_pkg::sts_t sts;

  tpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .node_a_i    (in_i.node_a),
    .node_b_i    (in_i.node_b),
    .node_c_i    (in_i.node_c),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .distance_o  (out_o.distance)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.opcode != tpd_pkg::OP_NOP) |=> !in_i.ready)
    else $error("accepted word did not start work");

  a_no_result_for_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.opcode != tpd_pkg::OP_QUERY) |=> !$rose(out_o.valid))
    else $error("result raised right after an insert");
`endif

endmodule
`default_nettype wire
